@@ rtl/rgb_led_spi_bit_encoder_core_assert.svh @@
// Assertion macros for the checker file.
`ifndef RGB_LED_SPI_BIT_ENCODER_CORE_ASSERT_SVH
`define RGB_LED_SPI_BIT_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define RGBENC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RGBENC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rgbenc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rgbenc_pkg;

    // APB register file
    localparam int          APB_ADDR_W          = 3;
    localparam int          APB_DATA_W          = 32;
    localparam logic        REG_IDX_BRIGHTNESS  = 1'b0;
    localparam logic [7:0]  BRIGHTNESS_RESET    = 8'd51;

    // nibble codes
    localparam logic [3:0]  NIBBLE_ONE          = 4'h7;
    localparam logic [3:0]  NIBBLE_ZERO         = 4'h4;

    // channel codes, also the output order
    localparam int          CH_NUM              = 3;
    localparam logic [1:0]  CH_GREEN            = 2'd0;
    localparam logic [1:0]  CH_RED              = 2'd1;
    localparam logic [1:0]  CH_BLUE             = 2'd2;

    // divider: 9 quotient bits (top one always zero), 3 per cycle
    localparam int          DIV_REM_W           = 10;
    localparam int          DIV_SH_W            = 9;
    localparam int          DIV_BITS_PER_CYCLE  = 3;
    localparam logic [1:0]  DIV_CNT_LAST        = 2'd2;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       normalize;
    } rgbenc_in_t;

    typedef struct packed {
        logic [31:0] code_word;
        logic [1:0]  channel;
        logic        last;
    } rgbenc_out_t;

    typedef struct packed {
        logic load;   // start a new division
        logic step;   // advance one iteration
    } rgbenc_lane_ctl_t;

    function automatic logic [31:0] byte_to_code_word(input logic [7:0] value);
        logic [31:0] word;
        word = '0;
        for (int i = 0; i < 8; i++) begin
            word[4*i +: 4] = value[i] ? NIBBLE_ONE : NIBBLE_ZERO;
        end
        return word;
    endfunction

endpackage

`default_nettype wire

@@ rtl/rgbenc_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One colour lane: scale product and restoring divider, 3 quotient bits/cycle.
module rgbenc_lane
    import rgbenc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire rgbenc_lane_ctl_t      ctl,
    input  wire logic [7:0]            value,
    input  wire logic [7:0]            brightness,
    input  wire logic                  normalize,
    input  wire logic [DIV_REM_W-1:0]  divisor,
    output logic [7:0]                 quot
);

    logic [DIV_REM_W-1:0] rem_reg, rem_next;
    logic [DIV_SH_W-1:0]  sh_reg,  sh_next;
    logic [DIV_REM_W-1:0] div_reg, div_next;
    logic [15:0]          prod;
    logic [DIV_REM_W-1:0] rem_step;
    logic [DIV_SH_W-1:0]  sh_step;

    // raw pass-through is a division of the byte by one
    assign prod = normalize ? (value * brightness) : {8'b0, value};

    always_comb begin
        logic [DIV_REM_W:0] trial;
        logic               qbit;
        rem_step = rem_reg;
        sh_step  = sh_reg;
        for (int k = 0; k < DIV_BITS_PER_CYCLE; k++) begin
            trial = {rem_step, sh_step[DIV_SH_W-1]};
            qbit  = (trial >= {1'b0, div_reg});
            if (qbit) begin
                rem_step = DIV_REM_W'(trial - {1'b0, div_reg});
            end else begin
                rem_step = trial[DIV_REM_W-1:0];
            end
            sh_step = {sh_step[DIV_SH_W-2:0], qbit};
        end
    end

    always_comb begin
        rem_next = rem_reg;
        sh_next  = sh_reg;
        div_next = div_reg;
        if (ctl.load) begin
            rem_next = {3'b0, prod[15:9]};
            sh_next  = prod[8:0];
            div_next = divisor;
        end else if (ctl.step) begin
            rem_next = rem_step;
            sh_next  = sh_step;
        end
    end

    // on the final step the quotient is forwarded before it lands
    assign quot = ctl.step ? sh_step[7:0] : sh_reg[7:0];

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        div_reg <= div_next;
    end

endmodule

`default_nettype wire

@@ rtl/rgbenc_merge.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Collects the three lane bytes and sends them as green, red, blue words.
module rgbenc_merge
    import rgbenc_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    load,
    input  wire logic [CH_NUM-1:0][7:0]  ch_byte,
    output logic                         can_load,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output rgbenc_out_t                  m_data
);

    logic                   valid_reg, valid_next;
    logic [1:0]             idx_reg,   idx_next;
    logic [CH_NUM-1:0][7:0] byte_reg,  byte_next;

    assign can_load = !valid_reg || (m_ready && idx_reg == CH_BLUE);
    assign m_valid  = valid_reg;

    always_comb begin
        m_data.code_word = byte_to_code_word(byte_reg[idx_reg]);
        m_data.channel   = idx_reg;
        m_data.last      = (idx_reg == CH_BLUE);
    end

    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        byte_next  = byte_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = CH_GREEN;
            byte_next  = ch_byte;
        end else if (valid_reg && m_ready) begin
            if (idx_reg == CH_BLUE) begin
                valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= CH_GREEN;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
        byte_reg <= byte_next;
    end

endmodule

`default_nettype wire

@@ rtl/rgb_led_spi_bit_encoder_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Pixel to SPI code-word encoder for single-wire RGB LED strips. Each
// request carries red, green, blue and a normalize flag; with normalize set
// every channel becomes floor(c * brightness / (red + green + blue + 1)),
// exact integer math, otherwise the raw byte is used. Three 32-bit words
// follow on the m_ channel in the order green, red, blue (channel 0, 1, 2,
// last on blue); each data bit, MSB first, becomes nibble 0x7 for a one
// or 0x4 for a zero, first nibble in bits 31:28. The three lane dividers
// each resolve 3 quotient bits per cycle and, if the output stage has room,
// a new request is taken on their final iteration; the output stage sends
// one word per cycle while m_ready is high. The green word is presented once
// the output stage has loaded the finished quotients. brightness sits at APB
// byte address 0 (resets to 51); writes are meant to happen only while the
// encoder is idle.
module rgb_led_spi_bit_encoder_core
    import rgbenc_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    // pixel requests
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire rgbenc_in_t             s_data,

    // code words
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output rgbenc_out_t                 m_data,

    // APB register port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]       prdata,
    output logic                        pready
);

    // ---------------------------------------------------------------
    // Register file: only brightness; index is the word address.
    // ---------------------------------------------------------------
    logic [7:0] bright_reg, bright_next;
    logic       reg_idx;
    logic       reg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign reg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        bright_next = bright_reg;
        if (reg_wr && reg_idx == REG_IDX_BRIGHTNESS) begin
            bright_next = pwdata[7:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == REG_IDX_BRIGHTNESS) begin
            prdata = {{(APB_DATA_W-8){1'b0}}, bright_reg};
        end
    end

    // ---------------------------------------------------------------
    // Divider sequencer, shared by the three lanes.
    //   busy : lanes are iterating, cnt counts the 3 iterations
    //   hold : quotients finished but the output stage was full
    // On the final iteration the quotients go straight to the output
    // stage if it can load, so a new request is taken at that same edge.
    // ---------------------------------------------------------------
    logic             busy_reg, busy_next;
    logic             hold_reg, hold_next;
    logic [1:0]       cnt_reg,  cnt_next;
    logic             last_step;
    logic             merge_can_load;
    logic             merge_load;
    logic             accept;
    rgbenc_lane_ctl_t lane_ctl;

    assign last_step  = busy_reg && (cnt_reg == DIV_CNT_LAST);
    assign merge_load = (last_step || hold_reg) && merge_can_load;
    assign s_ready    = (!busy_reg && !hold_reg) || merge_load;
    assign accept     = s_valid && s_ready;

    assign lane_ctl.load = accept;
    assign lane_ctl.step = busy_reg;

    always_comb begin
        busy_next = busy_reg;
        hold_next = hold_reg;
        cnt_next  = cnt_reg;
        if (accept) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (last_step) begin
            busy_next = 1'b0;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 2'd1;
        end
        if (last_step && !merge_can_load) begin
            hold_next = 1'b1;
        end else if (merge_load) begin
            hold_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bright_reg <= BRIGHTNESS_RESET;
            busy_reg   <= 1'b0;
            hold_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            bright_reg <= bright_next;
            busy_reg   <= busy_next;
            hold_reg   <= hold_next;
            cnt_reg    <= cnt_next;
        end
    end

    // ---------------------------------------------------------------
    // Lanes. The divisor is common; raw mode divides by one.
    // ---------------------------------------------------------------
    logic [DIV_REM_W-1:0]   divisor;
    logic [CH_NUM-1:0][7:0] lane_in;
    logic [CH_NUM-1:0][7:0] lane_quot;

    assign divisor = s_data.normalize
                   ? ({2'b0, s_data.red} + {2'b0, s_data.green}
                      + {2'b0, s_data.blue} + DIV_REM_W'(1))
                   : DIV_REM_W'(1);

    assign lane_in[CH_GREEN] = s_data.green;
    assign lane_in[CH_RED]   = s_data.red;
    assign lane_in[CH_BLUE]  = s_data.blue;

    for (genvar i = 0; i < CH_NUM; i++) begin : g_lane
        rgbenc_lane u_lane (
            .aclk       (aclk),
            .ctl        (lane_ctl),
            .value      (lane_in[i]),
            .brightness (bright_reg),
            .normalize  (s_data.normalize),
            .divisor    (divisor),
            .quot       (lane_quot[i])
        );
    end

    // ---------------------------------------------------------------
    // Output stage: holds one pixel, emits three words.
    // ---------------------------------------------------------------
    rgbenc_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (merge_load),
        .ch_byte  (lane_quot),
        .can_load (merge_can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire

@@ rtl/rgbenc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "rgb_led_spi_bit_encoder_core_assert.svh"

module rgbenc_checker
    import rgbenc_pkg::*;
(
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   m_valid,
    input wire logic                   m_ready,
    input wire rgbenc_out_t            m_data
);

    // stalled word holds
    `RGBENC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "word dropped under stall")

    // last marks blue and only blue
    `RGBENC_ASSERT_NOW(a_last_blue, m_valid, (m_data.last == (m_data.channel == CH_BLUE)) && (m_data.channel != 2'd3), "bad channel or last")

    // every nibble is 0x7 or 0x4
    `RGBENC_ASSERT_NOW(a_nibbles, m_valid, ((m_data.code_word & 32'hCCCC_CCCC) == 32'h4444_4444) && ((((m_data.code_word >> 1) ^ m_data.code_word) & 32'h1111_1111) == 32'h0), "illegal nibble")

    // words of one pixel come back to back in channel order
    `RGBENC_ASSERT_NEXT(a_ch_order, m_valid && m_ready && !m_data.last, m_valid && (m_data.channel == 2'($past(m_data.channel) + 2'd1)), "channel order broken")

endmodule

bind rgb_led_spi_bit_encoder_core rgbenc_checker u_rgbenc_checker (.*);

`default_nettype wire

@@ bench/rgb_led_spi_bit_encoder_core_tb.sv @@
`timescale 1ns / 1ps

module rgb_led_spi_bit_encoder_core_tb;
    import rgbenc_pkg::*;

    // APB byte addresses: brightness is register 0, the next slot is unmapped
    localparam logic [APB_ADDR_W-1:0] ADDR_BRIGHTNESS = {REG_IDX_BRIGHTNESS, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED   = 3'd4;

    // all-zero and all-one bytes after nibble expansion
    localparam logic [31:0] WORD_ZEROS = 32'h4444_4444;
    localparam logic [31:0] WORD_ONES  = 32'h7777_7777;

    localparam int RANDOM_PHASES    = 4;
    localparam int PIXELS_PER_PHASE = 33;

    // One row of the directed pixel list. An optional register write runs
    // first (with the encoder drained). Rows with known set carry the three
    // words typed in; the others go through the pixel predictor.
    typedef struct packed {
        logic                  wr_cfg;
        logic [APB_ADDR_W-1:0] cfg_addr;
        logic [7:0]            cfg_val;
        logic [7:0]            red;
        logic [7:0]            green;
        logic [7:0]            blue;
        logic                  norm;
        logic                  known;
        logic [31:0]           word_g;
        logic [31:0]           word_r;
        logic [31:0]           word_b;
    } pixel_row_t;

    localparam int DIR_ROWS = 21;

    pixel_row_t dir_rows [DIR_ROWS] = '{
        // reset brightness (51): raw extremes and bit patterns
        '{1'b0, ADDR_BRIGHTNESS, 8'd0, 8'h00, 8'h00, 8'h00, 1'b0,
          1'b1, WORD_ZEROS, WORD_ZEROS, WORD_ZEROS},
        '{1'b0, ADDR_BRIGHTNESS, 8'd0, 8'hFF, 8'hFF, 8'hFF, 1'b0,
          1'b1, WORD_ONES, WORD_ONES, WORD_ONES},
        '{1'b0, ADDR_BRIGHTNESS, 8'd0, 8'hFF, 8'h00, 8'h00, 1'b0,
          1'b1, WORD_ZEROS, WORD_ONES, WORD_ZEROS},
        '{1'b0, ADDR_BRIGHTNESS, 8'd0, 8'h00, 8'hFF, 8'h00, 1'b0,
          1'b1, WORD_ONES, WORD_ZEROS, WORD_ZEROS},
        '{1'b0, ADDR_BRIGHTNESS, 8'd0, 8'h00, 8'h00, 8'hFF, 1'b0,
          1'b1, WORD_ZEROS, WORD_ZEROS, WORD_ONES},
        // black pixel normalized: divisor is 1, stays black
        '{1'b0, ADDR_BRIGHTNESS, 8'd0, 8'h00, 8'h00, 8'h00, 1'b1,
          1'b1, WORD_ZEROS, WORD_ZEROS, WORD_ZEROS},
        // white normalized at 51: 255*51/766 = 16
        '{1'b0, ADDR_BRIGHTNESS, 8'd0, 8'hFF, 8'hFF, 8'hFF, 1'b1,
          1'b1, 32'h4447_4444, 32'h4447_4444, 32'h4447_4444},
        '{1'b0, ADDR_BRIGHTNESS, 8'd0, 8'hAA, 8'h55, 8'h0F, 1'b0,
          1'b1, 32'h4747_4747, 32'h7474_7474, 32'h4444_7777},
        '{1'b0, ADDR_BRIGHTNESS, 8'd0, 8'h80, 8'h01, 8'h7F, 1'b0,
          1'b0, '0, '0, '0},
        '{1'b0, ADDR_BRIGHTNESS, 8'd0, 8'd200, 8'd30, 8'd10, 1'b1,
          1'b0, '0, '0, '0},
        '{1'b0, ADDR_BRIGHTNESS, 8'd0, 8'd1, 8'd0, 8'd0, 1'b1,
          1'b0, '0, '0, '0},
        // full brightness: 255*255/256 = 254
        '{1'b1, ADDR_BRIGHTNESS, 8'd255, 8'hFF, 8'h00, 8'h00, 1'b1,
          1'b1, WORD_ZEROS, 32'h7777_7774, WORD_ZEROS},
        '{1'b0, ADDR_BRIGHTNESS, 8'd0, 8'd0, 8'd0, 8'd1, 1'b1,
          1'b0, '0, '0, '0},
        '{1'b0, ADDR_BRIGHTNESS, 8'd0, 8'd85, 8'd85, 8'd85, 1'b1,
          1'b0, '0, '0, '0},
        // brightness zero blanks every normalized pixel
        '{1'b1, ADDR_BRIGHTNESS, 8'd0, 8'hFF, 8'hFF, 8'hFF, 1'b1,
          1'b1, WORD_ZEROS, WORD_ZEROS, WORD_ZEROS},
        '{1'b0, ADDR_BRIGHTNESS, 8'd0, 8'd17, 8'd200, 8'd3, 1'b1,
          1'b0, '0, '0, '0},
        '{1'b0, ADDR_BRIGHTNESS, 8'd0, 8'd17, 8'd200, 8'd3, 1'b0,
          1'b0, '0, '0, '0},
        // write to an unmapped slot must leave brightness alone
        '{1'b1, ADDR_UNMAPPED, 8'hFF, 8'd100, 8'd50, 8'd25, 1'b1,
          1'b0, '0, '0, '0},
        '{1'b1, ADDR_BRIGHTNESS, 8'd1, 8'hFF, 8'h00, 8'h00, 1'b1,
          1'b0, '0, '0, '0},
        '{1'b1, ADDR_BRIGHTNESS, 8'd128, 8'd128, 8'd64, 8'd32, 1'b1,
          1'b0, '0, '0, '0},
        '{1'b0, ADDR_BRIGHTNESS, 8'd0, 8'hFF, 8'h00, 8'hFF, 1'b1,
          1'b0, '0, '0, '0}
    };

    // clock, reset and DUT-facing signals; the driven ones are known from time zero
    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    wire                   s_ready;
    rgbenc_in_t            s_data  = '0;
    wire                   m_valid;
    logic                  m_ready = 1'b0;
    rgbenc_out_t           m_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // predictor state: shadow of the brightness register
    logic [7:0]  bright_shadow = BRIGHTNESS_RESET;
    // code words still owed by the encoder, oldest first
    rgbenc_out_t pending_words [$];
    rgbenc_out_t oldest_word;
    int          mismatch_count = 0;

    // idling odds in percent, changed per phase
    int          send_idle_pct = 0;
    int          sink_stall_pct = 0;

    rgb_led_spi_bit_encoder_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 8 ns period
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Fixed ceiling on the whole run; the real run is a small fraction of it.
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // Byte to SPI word: MSB first, one nibble per bit, first nibble on top.
    function automatic logic [31:0] spi_word(input logic [7:0] level);
        logic [31:0] word;
        word = '0;
        for (int i = 7; i >= 0; i--) begin
            word = {word[27:0], level[i] ? NIBBLE_ONE : NIBBLE_ZERO};
        end
        return word;
    endfunction

    // floor(level * brightness / (sum + 1)); sum >= level keeps it in 8 bits
    function automatic logic [7:0] scaled_level(input logic [7:0] level,
                                                input logic [9:0] total);
        logic [15:0] prod;
        logic [10:0] divisor;
        logic [15:0] quot;
        prod    = level * bright_shadow;
        divisor = total + 11'd1;
        quot    = prod / divisor;
        return quot[7:0];
    endfunction

    function automatic logic [7:0] rand_level();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic queue_word(input logic [31:0] word, input logic [1:0] chan);
        rgbenc_out_t w;
        w.code_word = word;
        w.channel   = chan;
        w.last      = (chan == CH_BLUE);
        pending_words.push_back(w);
    endtask

    // Predicted words for one pixel, green / red / blue.
    task automatic queue_pixel_words(input rgbenc_in_t px);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [9:0] total;
        r = px.red;
        g = px.green;
        b = px.blue;
        if (px.normalize) begin
            total = r + g + b;
            r = scaled_level(px.red, total);
            g = scaled_level(px.green, total);
            b = scaled_level(px.blue, total);
        end
        queue_word(spi_word(g), CH_GREEN);
        queue_word(spi_word(r), CH_RED);
        queue_word(spi_word(b), CH_BLUE);
    endtask

    // Present one pixel request, hold it until taken, then maybe go idle.
    // Called right after a rising edge; returns right after one.
    task automatic send_pixel(input rgbenc_in_t px, input logic known,
                              input logic [31:0] wg, input logic [31:0] wr,
                              input logic [31:0] wb);
        s_valid <= 1'b1;
        s_data  <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (known) begin
            queue_word(wg, CH_GREEN);
            queue_word(wr, CH_RED);
            queue_word(wb, CH_BLUE);
        end else begin
            queue_pixel_words(px);
        end
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
    endtask

    // Stop sending and wait until every owed word has come out.
    task automatic drain_encoder();
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
    endtask

    // Back-to-back APB write then read of brightness. Upper data bits are
    // random junk; only the low byte lands in the register.
    task automatic program_reg(input logic [APB_ADDR_W-1:0] addr,
                               input logic [7:0] value);
        logic [31:0] data;
        data       = $urandom();
        data[7:0]  = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (addr == ADDR_BRIGHTNESS) bright_shadow = value;
        // read back in the next transfer
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_BRIGHTNESS;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== {24'd0, bright_shadow}) begin
            $error("prdata: expected %h, actual %h", {24'd0, bright_shadow}, prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result side: random backpressure plus the scoreboard. Values read here
    // are the ones from just before the edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                $error("unexpected code word %h on channel %0d",
                       m_data.code_word, m_data.channel);
                mismatch_count++;
            end else begin
                oldest_word = pending_words.pop_front();
                if (m_data.code_word !== oldest_word.code_word) begin
                    $error("code_word: expected %h, actual %h",
                           oldest_word.code_word, m_data.code_word);
                    mismatch_count++;
                end
                if (m_data.channel !== oldest_word.channel) begin
                    $error("channel: expected %0d, actual %0d",
                           oldest_word.channel, m_data.channel);
                    mismatch_count++;
                end
                if (m_data.last !== oldest_word.last) begin
                    $error("last: expected %b, actual %b",
                           oldest_word.last, m_data.last);
                    mismatch_count++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Main sequence: reset, directed rows at full speed, then random pixels
    // under four idling mixes, each preceded by a fresh brightness.
    initial begin
        rgbenc_in_t px;
        pixel_row_t row;
        logic [7:0] bright_pick;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part
        for (int i = 0; i < DIR_ROWS; i++) begin
            row = dir_rows[i];
            if (row.wr_cfg) begin
                drain_encoder();
                program_reg(row.cfg_addr, row.cfg_val);
            end
            px.red       = row.red;
            px.green     = row.green;
            px.blue      = row.blue;
            px.normalize = row.norm;
            send_pixel(px, row.known, row.word_g, row.word_r, row.word_b);
        end

        // random part: no idling, sender gaps, receiver stalls, both
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_encoder();
            case (phase)
                0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_idle_pct = 70; sink_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  sink_stall_pct = 70; end
                default: begin send_idle_pct = 38; sink_stall_pct = 38; end
            endcase
            bright_pick = (phase == 1) ? 8'd255 : 8'($urandom_range(255));
            program_reg(ADDR_BRIGHTNESS, bright_pick);
            for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
                px.red       = rand_level();
                px.green     = rand_level();
                px.blue      = rand_level();
                px.normalize = ($urandom_range(9) < 6);
                send_pixel(px, 1'b0, '0, '0, '0);
            end
        end

        drain_encoder();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
